>>> hw/rtl/cfpq_pkg.sv
// Shared types, constants and helpers for the command frame parser queue.
// No dependencies; imported by cfpq_parser and command_frame_parser_queue.
package cfpq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int USED_W      = PTR_W + 1;
    localparam int CNT_PAD_W   = (USED_W > 3) ? USED_W : 3;

    localparam int DIR_W   = 3;
    localparam int VALUE_W = 16;
    localparam int ENTRY_W = DIR_W + VALUE_W;

    localparam logic [7:0] REG_START_CHAR  = 8'd0;
    localparam logic [7:0] REG_COMMAND_PIN = 8'd1;

    localparam logic [7:0] START_CHAR_RESET = 8'd94;

    localparam logic [7:0] CHAR_F    = 8'h46;
    localparam logic [7:0] CHAR_B    = 8'h42;
    localparam logic [7:0] CHAR_R    = 8'h52;
    localparam logic [7:0] CHAR_L    = 8'h4C;
    localparam logic [7:0] CHAR_T    = 8'h54;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_P    = 8'h50;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [DIR_W-1:0] DIR_FORWARD = 3'd0;
    localparam logic [DIR_W-1:0] DIR_REVERSE = 3'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT   = 3'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT    = 3'd3;
    localparam logic [DIR_W-1:0] DIR_TURN    = 3'd4;
    localparam logic [DIR_W-1:0] DIR_ALIGN   = 3'd5;
    localparam logic [DIR_W-1:0] DIR_PID     = 3'd6;

    localparam logic [1:0] PIN_LAST = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PIN,
        PH_DIR,
        PH_FIRST,
        PH_DIGITS
    } phase_t;

    typedef struct packed {
        logic               done;
        logic [DIR_W-1:0]   dir;
        logic [VALUE_W-1:0] value;
    } cmd_t;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/cfpq_parser.sv
// Byte-level command parser: start char, PIN, direction letter, decimal digits.
// Depends on cfpq_pkg; reports a completed command in the same cycle.
module cfpq_parser
    import cfpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    input  logic [7:0]  start_char,
    input  logic [31:0] command_pin,
    output cmd_t        cmd
);

    phase_t             phase_reg, phase_next;
    logic [1:0]         pos_reg, pos_next;
    logic [DIR_W-1:0]   dir_reg, dir_next;
    logic [VALUE_W-1:0] val_reg, val_next;

    logic               is_digit;
    logic [VALUE_W-1:0] digit;
    logic [7:0]         want;
    logic               letter_ok;
    logic [DIR_W-1:0]   letter_dir;

    assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
    assign digit    = VALUE_W'(data_byte - CHAR_ZERO);

    always_comb
    begin
        case (pos_reg)
            2'd0:    want = command_pin[31:24];
            2'd1:    want = command_pin[23:16];
            2'd2:    want = command_pin[15:8];
            default: want = command_pin[7:0];
        endcase
    end

    always_comb
    begin
        letter_ok  = 1'b1;
        letter_dir = DIR_FORWARD;
        case (data_byte)
            CHAR_F:  letter_dir = DIR_FORWARD;
            CHAR_B:  letter_dir = DIR_REVERSE;
            CHAR_R:  letter_dir = DIR_RIGHT;
            CHAR_L:  letter_dir = DIR_LEFT;
            CHAR_T:  letter_dir = DIR_TURN;
            CHAR_A:  letter_dir = DIR_ALIGN;
            CHAR_P:  letter_dir = DIR_PID;
            default: letter_ok  = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        dir_next   = dir_reg;
        val_next   = val_reg;
        cmd.done   = 1'b0;
        cmd.dir    = dir_reg;
        cmd.value  = val_reg;

        // non-digit closes a digit run
        if (phase_reg == PH_DIGITS && !is_digit)
        begin
            cmd.done   = 1'b1;
            phase_next = PH_IDLE;
        end

        if (data_byte == start_char)
        begin
            phase_next = PH_PIN;
            pos_next   = '0;
            dir_next   = '0;
            val_next   = '0;
        end
        else
        begin
            case (phase_next)
                PH_PIN:
                begin
                    if (data_byte != want)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (pos_reg == PIN_LAST)
                    begin
                        pos_next   = '0;
                        phase_next = PH_DIR;
                    end
                    else
                    begin
                        pos_next = pos_reg + 2'd1;
                    end
                end
                PH_DIR:
                begin
                    if (!letter_ok)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        dir_next   = letter_dir;
                        phase_next = PH_FIRST;
                    end
                end
                PH_FIRST, PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        val_next   = (val_reg << 3) + (val_reg << 1) + digit;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (frame_end)
        begin
            if (phase_next == PH_DIGITS)
            begin
                cmd.done  = 1'b1;
                cmd.dir   = dir_next;
                cmd.value = val_next;
            end
            phase_next = PH_IDLE;
            pos_next   = '0;
        end

        if (!step)
        begin
            cmd.done = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            dir_reg   <= '0;
            val_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            dir_reg   <= dir_next;
            val_reg   <= val_next;
        end
    end

endmodule

>>> hw/rtl/command_frame_parser_queue.sv
// Top level: command parser feeding a ring queue of parsed commands.
// Depends on cfpq_pkg and cfpq_parser.
//
// channel  dir  tdata (low bit up)                      tuser / tlast
// s_*      in   data_byte[7:0]                          tuser action, tlast frame_end
// m_*      out  direction[2:0] duration[18:3] count     tuser stored,dropped,pop_valid
// cfg_*    in   cfg_index selects register, cfg_data    always ready
//
// One request per cycle while s_tready is high; results appear the cycle after.
// The output register holds a result while m_tready is low; a new request is
// taken whenever that register is empty or being drained in the same cycle.
// Reset clears parse state, queue pointers and restores register defaults.
module command_frame_parser_queue
    import cfpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tuser,   // action
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // direction[2:0], duration[18:3], queue_count[21:19], zero
    output logic [2:0]  m_tuser,   // command_stored, command_dropped, pop_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [7:0]   start_char_reg;
    logic [31:0]  pin_reg;

    logic [ENTRY_W-1:0] store [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;

    logic         out_valid_reg;
    logic [23:0]  out_data_reg;
    logic [2:0]   out_user_reg, out_user_next;

    logic         accept;
    logic         byte_step;
    cmd_t         cmd;
    logic         full;
    logic         push;
    logic         drop;
    logic         pop;
    logic [USED_W-1:0]  used;
    logic [CNT_PAD_W-1:0] used_pad;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign byte_step = accept && !s_tuser;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    cfpq_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (byte_step),
        .data_byte   (s_tdata),
        .frame_end   (s_tlast),
        .start_char  (start_char_reg),
        .command_pin (pin_reg),
        .cmd         (cmd)
    );

    assign full = (ptr_next(wr_ptr_reg) == rd_ptr_reg);
    assign push = cmd.done && !full;
    assign drop = cmd.done && full;
    assign pop  = accept && s_tuser && (wr_ptr_reg != rd_ptr_reg);

    always_comb
    begin
        wr_ptr_next = push ? ptr_next(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_next(rd_ptr_reg) : rd_ptr_reg;

        if (wr_ptr_next >= rd_ptr_next)
        begin
            used = USED_W'(wr_ptr_next) - USED_W'(rd_ptr_next);
        end
        else
        begin
            used = USED_W'(QUEUE_DEPTH) - USED_W'(rd_ptr_next) + USED_W'(wr_ptr_next);
        end
        used_pad = CNT_PAD_W'(used);

        out_user_next = {pop, drop, push};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= {cmd.dir, cmd.value};
        end
    end

    // head entry is read straight into the output register on a pop
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_user_reg <= out_user_next;
            if (pop)
            begin
                out_data_reg <= {2'b00, used_pad[2:0], store[rd_ptr_reg][VALUE_W-1:0],
                                 store[rd_ptr_reg][ENTRY_W-1:VALUE_W]};
            end
            else
            begin
                out_data_reg <= {2'b00, used_pad[2:0], {(VALUE_W + DIR_W){1'b0}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_char_reg <= START_CHAR_RESET;
            pin_reg        <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_START_CHAR:  start_char_reg <= cfg_data[7:0];
                REG_COMMAND_PIN: pin_reg        <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

>>> bench/command_frame_parser_queue_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for command_frame_parser_queue: byte and pop streams in,
// every result checked against a cycle-free model of the parser and queue.
// Depends on cfpq_pkg and the command_frame_parser_queue RTL.
module command_frame_parser_queue_tb
    import cfpq_pkg::*;
;

    localparam longint LIMIT_NS = 5_000_000;

    localparam logic [7:0] DIR_LETTERS [7] =
        '{CHAR_F, CHAR_B, CHAR_R, CHAR_L, CHAR_T, CHAR_A, CHAR_P};

    typedef enum int {TERM_FRAME_END, TERM_BYTE, TERM_START} term_t;

    typedef struct packed {
        logic               stored;
        logic               dropped;
        logic               pop_valid;
        logic [DIR_W-1:0]   dir;
        logic [VALUE_W-1:0] dur;
        logic [2:0]         count;
    } queue_result_t;

    class command_queue_tracker;
        logic [7:0]         start_char;
        logic [31:0]        pin;
        phase_t             phase;
        logic [1:0]         pin_pos;
        logic [DIR_W-1:0]   dir;
        logic [VALUE_W-1:0] value;
        logic [ENTRY_W-1:0] slots [QUEUE_DEPTH];
        int unsigned        wr_ptr;
        int unsigned        rd_ptr;
        queue_result_t      expected_results [$];
        int unsigned        mismatches;

        function new();
            start_char = START_CHAR_RESET;
            pin        = '0;
            phase      = PH_IDLE;
            pin_pos    = '0;
            dir        = '0;
            value      = '0;
            wr_ptr     = 0;
            rd_ptr     = 0;
            mismatches = 0;
        endfunction

        function void write_register(logic [7:0] idx, logic [31:0] data);
            if (idx == REG_START_CHAR)
                start_char = data[7:0];
            else if (idx == REG_COMMAND_PIN)
                pin = data;
        endfunction

        function int unsigned bump(int unsigned p);
            return (p + 1) % QUEUE_DEPTH;
        endfunction

        // returns {stored, dropped}
        function logic [1:0] push_command();
            if (bump(wr_ptr) == rd_ptr)
                return 2'b01;
            slots[wr_ptr] = {dir, value};
            wr_ptr = bump(wr_ptr);
            return 2'b10;
        endfunction

        function void note_request(logic act, logic [7:0] b, logic fend);
            queue_result_t      r;
            logic               digit;
            logic [7:0]         want;
            logic [ENTRY_W-1:0] entry;
            r = '0;
            if (act)
            begin
                if (wr_ptr != rd_ptr)
                begin
                    entry       = slots[rd_ptr];
                    r.pop_valid = 1'b1;
                    r.dir       = entry[ENTRY_W-1:VALUE_W];
                    r.dur       = entry[VALUE_W-1:0];
                    rd_ptr      = bump(rd_ptr);
                end
            end
            else
            begin
                digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
                if (phase == PH_DIGITS && !digit)
                begin
                    {r.stored, r.dropped} = push_command();
                    phase = PH_IDLE;
                end
                if (b == start_char)
                begin
                    phase   = PH_PIN;
                    pin_pos = '0;
                    dir     = '0;
                    value   = '0;
                end
                else if (phase == PH_PIN)
                begin
                    want = pin[8 * (3 - int'(pin_pos)) +: 8];
                    if (b != want)
                        phase = PH_IDLE;
                    else if (pin_pos == PIN_LAST)
                    begin
                        pin_pos = '0;
                        phase   = PH_DIR;
                    end
                    else
                        pin_pos = pin_pos + 2'd1;
                end
                else if (phase == PH_DIR)
                begin
                    phase = PH_FIRST;
                    case (b)
                        CHAR_F:  dir = DIR_FORWARD;
                        CHAR_B:  dir = DIR_REVERSE;
                        CHAR_R:  dir = DIR_RIGHT;
                        CHAR_L:  dir = DIR_LEFT;
                        CHAR_T:  dir = DIR_TURN;
                        CHAR_A:  dir = DIR_ALIGN;
                        CHAR_P:  dir = DIR_PID;
                        default: phase = PH_IDLE;
                    endcase
                end
                else if (phase == PH_FIRST || phase == PH_DIGITS)
                begin
                    if (digit)
                    begin
                        value = value * 16'd10 + 16'(b - CHAR_ZERO);
                        phase = PH_DIGITS;
                    end
                    else
                        phase = PH_IDLE;
                end
                if (fend)
                begin
                    if (phase == PH_DIGITS)
                        {r.stored, r.dropped} = push_command();
                    phase   = PH_IDLE;
                    pin_pos = '0;
                end
            end
            r.count = 3'((wr_ptr + QUEUE_DEPTH - rd_ptr) % QUEUE_DEPTH);
            expected_results.push_back(r);
        endfunction

        function void check_field(string name, int unsigned exp_v, int unsigned got);
            if (exp_v != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [2:0] user, logic [23:0] data);
            queue_result_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual tuser=%h tdata=%h",
                         $time, user, data);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            check_field("command_stored", want.stored, user[0]);
            check_field("command_dropped", want.dropped, user[1]);
            check_field("pop_valid", want.pop_valid, user[2]);
            check_field("direction", want.dir, data[2:0]);
            check_field("duration", want.dur, data[18:3]);
            check_field("queue_count", want.count, data[21:19]);
            check_field("tdata pad", 0, data[23:22]);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [31:0] cfg_data;

    command_queue_tracker tracker = new();
    int unsigned items_sent = 0;
    int unsigned ready_hold = 0;
    bit          no_idle    = 1'b0;

    command_frame_parser_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    always @(posedge clk)
    begin
        if (ready_hold != 0)
        begin
            m_tready <= 1'b0;
            ready_hold = ready_hold - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            ready_hold = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tuser, m_tdata);
    end

    task automatic send_item(input logic act, input logic [7:0] b, input logic fend);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        s_tlast  <= fend;
        do @(posedge clk); while (!s_tready);
        tracker.note_request(act, b, fend);
        items_sent++;
    endtask

    task automatic send_command(input logic [7:0] letter, input longint unsigned value,
                                input int ndigits, input term_t term);
        longint unsigned scale;
        int              i;
        logic [7:0]      tail;
        send_item(1'b0, tracker.start_char, 1'b0);
        for (i = 3; i >= 0; i--)
            send_item(1'b0, tracker.pin[8 * i +: 8], 1'b0);
        send_item(1'b0, letter, 1'b0);
        scale = 1;
        for (i = 1; i < ndigits; i++)
            scale = scale * 10;
        for (i = 0; i < ndigits; i++)
        begin
            send_item(1'b0, CHAR_ZERO + 8'((value / scale) % 10),
                      term == TERM_FRAME_END && i == ndigits - 1);
            scale = scale / 10;
        end
        case (term)
            TERM_BYTE:
            begin
                do tail = 8'($urandom);
                while ((tail >= CHAR_ZERO && tail <= CHAR_NINE) || tail == tracker.start_char);
                send_item(1'b0, tail, $urandom_range(0, 3) == 0);
            end
            TERM_START: send_item(1'b0, tracker.start_char, 1'b0);
            default: ;
        endcase
    endtask

    // command prefix with random corruption and an optional early frame end
    task automatic send_damaged_command();
        logic [7:0] seq [8];
        int         len;
        int         i;
        bit         cut;
        seq[0] = tracker.start_char;
        for (i = 0; i < 4; i++)
            seq[1 + i] = tracker.pin[8 * (3 - i) +: 8];
        seq[5] = DIR_LETTERS[$urandom_range(0, 6)];
        seq[6] = CHAR_ZERO + 8'($urandom_range(0, 9));
        seq[7] = CHAR_ZERO + 8'($urandom_range(0, 9));
        len = $urandom_range(1, 8);
        cut = 1'($urandom);
        for (i = 0; i < len; i++)
            send_item(1'b0, ($urandom_range(0, 3) == 0) ? 8'($urandom) : seq[i],
                      cut && i == len - 1);
    endtask

    task automatic run_random(input int unsigned target, input int unsigned pop_pct);
        int unsigned r;
        int          ndigits;
        while (items_sent < target)
        begin
            no_idle = ($urandom_range(0, 9) == 0);
            r = $urandom_range(0, 99);
            if (r < pop_pct)
                send_item(1'b1, 8'($urandom), 1'($urandom));
            else if (r < pop_pct + 12)
                send_damaged_command();
            else if (r < pop_pct + 20)
                send_item(1'b0, 8'($urandom), $urandom_range(0, 4) == 0);
            else
            begin
                ndigits = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 10)
                                                      : $urandom_range(1, 5);
                send_command(DIR_LETTERS[$urandom_range(0, 6)], {$urandom, $urandom},
                             ndigits, term_t'($urandom_range(0, 2)));
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tracker.expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_register(input logic [7:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        tracker.write_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reconfigure(input logic [7:0] start, input logic [31:0] pin);
        wait_drained();
        program_register(REG_START_CHAR, {24'h0, start});
        program_register(REG_COMMAND_PIN, pin);
    endtask

    initial
    begin
        #(LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        m_tready  <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: pop on empty, zero-byte pin, shortest and largest values
        send_item(1'b1, 8'hFF, 1'b1);
        send_command(CHAR_F, 0, 1, TERM_FRAME_END);
        send_command(CHAR_P, 65535, 5, TERM_START);
        send_item(1'b1, 8'h00, 1'b0);
        send_item(1'b1, 8'hFF, 1'b1);
        send_item(1'b0, 8'h00, 1'b0);
        send_item(1'b0, 8'hFF, 1'b1);
        run_random(items_sent + 250, 25);

        reconfigure(8'h00, 32'hFFFF_FFFF);
        run_random(items_sent + 250, 5);

        reconfigure(8'hFF, 32'h0000_0000);
        run_random(items_sent + 250, 50);

        reconfigure(8'h23, 32'h3761_305A);
        run_random(items_sent + 300, 30);

        reconfigure(8'($urandom), $urandom);
        run_random(items_sent + 300, 20);

        reconfigure(START_CHAR_RESET, 32'h3132_3334);
        run_random(items_sent + 350, 35);

        wait_drained();
        repeat (10) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/cfpq_pkg.sv
hw/rtl/cfpq_parser.sv
hw/rtl/command_frame_parser_queue.sv
bench/command_frame_parser_queue_tb.sv
